// ===== hw/rtl/sast_pkg.sv =====
// Shared types and constants for the segment/box slab test pipeline.
package sast_pkg;

  localparam int WORD   = 32;
  localparam int DIFF_W = WORD + 1;
  localparam int AXES   = 3;
  localparam int LANES  = 2 * AXES;
  localparam int QBITS  = 32;
  localparam int T_W    = WORD + 2;

  // One division in flight: partial remainder, dividend bits still to shift
  // in, quotient so far, divisor magnitude, result sign, overflow.
  typedef struct packed {
    logic [WORD-1:0] rem;
    logic [WORD-1:0] num;
    logic [QBITS-1:0] quo;
    logic [WORD-1:0] den;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [AXES-1:0]   dz;
    logic [AXES-1:0]   ins;
  } item_t;

endpackage

// ===== hw/rtl/sast_div_cell.sv =====
// Restoring-division cell: one quotient bit for all six lanes per en cycle.
module sast_div_cell import sast_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  item_t nxt;

  always_comb begin
    logic [WORD:0] t;
    logic          qb;
    nxt = in_item;
    for (int l = 0; l < LANES; l++) begin
      t  = {in_item.lane[l].rem, in_item.lane[l].num[WORD-1]};
      qb = (t >= {1'b0, in_item.lane[l].den});
      if (qb) begin
        t = t - {1'b0, in_item.lane[l].den};
      end
      nxt.lane[l].rem = t[WORD-1:0];
      nxt.lane[l].num = {in_item.lane[l].num[WORD-2:0], 1'b0};
      nxt.lane[l].quo = {in_item.lane[l].quo[QBITS-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nxt;
    end
  end

endmodule

// ===== hw/rtl/sast_resolve.sv =====
// Saturation, per-axis sort, entry/exit reduction and hit decision.
module sast_resolve import sast_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output logic  hit
);

  localparam logic signed [T_W-1:0] ONE     = T_W'(1) << FRAC_BITS;
  localparam logic signed [T_W-1:0] NEG_INF = {2'b10, {(T_W-2){1'b0}}};
  localparam logic signed [T_W-1:0] POS_INF = {2'b01, {(T_W-2){1'b1}}};

  logic [2:0] vld;
  logic signed [WORD-1:0] t1 [LANES];
  logic [AXES-1:0] dz1, ins1;
  logic signed [T_W-1:0] ent2 [AXES];
  logic signed [T_W-1:0] ext2 [AXES];
  logic ok2, ok3;
  logic signed [T_W-1:0] near3, far3;

  logic signed [WORD-1:0] t_next [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (in_item.lane[l].neg) begin
        if (in_item.lane[l].ovf || in_item.lane[l].quo > 32'h8000_0000)
          t_next[l] = 32'sh8000_0000;
        else
          t_next[l] = -$signed(in_item.lane[l].quo);
      end else begin
        if (in_item.lane[l].ovf || in_item.lane[l].quo[QBITS-1])
          t_next[l] = 32'sh7fff_ffff;
        else
          t_next[l] = $signed(in_item.lane[l].quo);
      end
    end
  end

  logic signed [T_W-1:0] ent_next [AXES];
  logic signed [T_W-1:0] ext_next [AXES];
  always_comb begin
    logic signed [T_W-1:0] a, b;
    for (int x = 0; x < AXES; x++) begin
      a = T_W'(t1[2*x]);
      b = T_W'(t1[2*x+1]);
      if (dz1[x]) begin
        ent_next[x] = NEG_INF;
        ext_next[x] = POS_INF;
      end else if (a < b) begin
        ent_next[x] = a;
        ext_next[x] = b;
      end else begin
        ent_next[x] = b;
        ext_next[x] = a;
      end
    end
  end

  logic signed [T_W-1:0] near_next, far_next;
  always_comb begin
    near_next = ent2[0];
    far_next  = ext2[0];
    for (int x = 1; x < AXES; x++) begin
      if (ent2[x] > near_next) near_next = ent2[x];
      if (ext2[x] < far_next)  far_next  = ext2[x];
    end
  end

  logic hit_next;
  always_comb begin
    hit_next = ok3;
    if ((near3 < 0 && far3 < 0) || (near3 > ONE && far3 > ONE)) hit_next = 1'b0;
    if (!(near3 < far3)) hit_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[1:0], in_vld};
      out_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= t_next;
      dz1   <= in_item.dz;
      ins1  <= in_item.ins;
      ent2  <= ent_next;
      ext2  <= ext_next;
      ok2   <= &(~dz1 | ins1);
      near3 <= near_next;
      far3  <= far_next;
      ok3   <= ok2;
      hit   <= hit_next;
    end
  end

endmodule

// ===== hw/rtl/segment_aabb_slab_test_core.sv =====
// Top: segment vs axis-aligned box slab test, one request per cycle unless stalled.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | box_min_*, box_max_*, seg_origin_*, seg_dir_*
//   out     | out_valid / out_ready | hit
//
// Throughput is one request per cycle unless the output stalls. Stages: one
// input stage, 32 division cells (one quotient bit each), four resolve stages.
// The whole pipeline moves together; it halts only while a result waits
// in the output register with out_ready low, and in_ready follows that.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
module segment_aabb_slab_test_core import sast_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [WORD-1:0] box_min_x,
  input  logic signed [WORD-1:0] box_min_y,
  input  logic signed [WORD-1:0] box_min_z,
  input  logic signed [WORD-1:0] box_max_x,
  input  logic signed [WORD-1:0] box_max_y,
  input  logic signed [WORD-1:0] box_max_z,
  input  logic signed [WORD-1:0] seg_origin_x,
  input  logic signed [WORD-1:0] seg_origin_y,
  input  logic signed [WORD-1:0] seg_origin_z,
  input  logic signed [WORD-1:0] seg_dir_x,
  input  logic signed [WORD-1:0] seg_dir_y,
  input  logic signed [WORD-1:0] seg_dir_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit
);

  localparam int NW = DIFF_W + FRAC_BITS;

  // Global advance: everything shifts unless the output is stuck.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [WORD-1:0] lo [AXES];
  logic signed [WORD-1:0] hi [AXES];
  logic signed [WORD-1:0] org [AXES];
  logic signed [WORD-1:0] dir [AXES];
  always_comb begin
    lo[0] = box_min_x;    lo[1] = box_min_y;    lo[2] = box_min_z;
    hi[0] = box_max_x;    hi[1] = box_max_y;    hi[2] = box_max_z;
    org[0] = seg_origin_x; org[1] = seg_origin_y; org[2] = seg_origin_z;
    dir[0] = seg_dir_x;   dir[1] = seg_dir_y;   dir[2] = seg_dir_z;
  end

  // Input stage: exact 33-bit differences and the inside-slab flags.
  logic                     s0_vld;
  logic signed [DIFF_W-1:0] s0_diff [LANES];
  logic signed [WORD-1:0]   s0_dir [AXES];
  logic [AXES-1:0]          s0_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < AXES; x++) begin
        s0_diff[2*x]   <= DIFF_W'(lo[x]) - DIFF_W'(org[x]);
        s0_diff[2*x+1] <= DIFF_W'(hi[x]) - DIFF_W'(org[x]);
        s0_dir[x]      <= dir[x];
        // origin within the slab, either corner order, bounds included
        s0_ins[x] <= (org[x] >= lo[x] && org[x] <= hi[x]) ||
                     (org[x] >= hi[x] && org[x] <= lo[x]);
      end
    end
  end

  // Division setup: magnitudes, sign, and the upper dividend bits as the
  // starting remainder. If those alone reach the divisor, the 32-bit
  // quotient overflows and saturates later.
  item_t prep;
  always_comb begin
    logic [DIFF_W-1:0] amag;
    logic [WORD-1:0]   dmag;
    logic [NW-1:0]     nval;
    logic [WORD-1:0]   top;
    for (int l = 0; l < LANES; l++) begin
      amag = s0_diff[l][DIFF_W-1] ? DIFF_W'(-s0_diff[l]) : DIFF_W'(s0_diff[l]);
      dmag = s0_dir[l/2][WORD-1] ? WORD'(-s0_dir[l/2]) : WORD'(s0_dir[l/2]);
      nval = {amag, {FRAC_BITS{1'b0}}};
      top  = WORD'(nval[NW-1:WORD]);
      prep.lane[l].rem = top;
      prep.lane[l].num = nval[WORD-1:0];
      prep.lane[l].quo = '0;
      prep.lane[l].den = dmag;
      prep.lane[l].neg = s0_diff[l][DIFF_W-1] ^ s0_dir[l/2][WORD-1];
      prep.lane[l].ovf = (top >= dmag);
    end
    for (int x = 0; x < AXES; x++) begin
      prep.dz[x] = (s0_dir[x] == '0);
    end
    prep.ins = s0_ins;
  end

  // Chain of division cells, one quotient bit per cell.
  logic  c_vld  [QBITS+1];
  item_t c_item [QBITS+1];
  assign c_vld[0]  = s0_vld;
  assign c_item[0] = prep;

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    sast_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (c_vld[k]),
      .in_item  (c_item[k]),
      .out_vld  (c_vld[k+1]),
      .out_item (c_item[k+1])
    );
  end

  // Saturate, sort per axis, reduce, decide; last stage is the output register.
  sast_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld[QBITS]),
    .in_item (c_item[QBITS]),
    .out_vld (out_valid),
    .hit     (hit)
  );

endmodule

// ===== tb/sv/tb_segment_aabb_slab_test_core.sv =====
// Testbench for segment_aabb_slab_test_core: directed table plus random segment/box requests.
module tb_segment_aabb_slab_test_core;
  import sast_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1250;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint T_NONE_LO = -(64'sd1 <<< 62);
  localparam longint T_NONE_HI = (64'sd1 <<< 62);
  localparam logic [31:0] Q1 = 32'h0001_0000;

  // expect_hit codes for the directed table: either a typed-in value or
  // "ask the predictor".
  typedef enum logic [1:0] {EXP_MISS, EXP_HIT, EXP_PREDICT} exp_e;

  typedef struct {
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    logic signed [31:0] org  [3];
    logic signed [31:0] dir  [3];
  } seg_req_t;

  typedef struct {
    seg_req_t req;
    exp_e     exp;
  } dir_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] box_min_x, box_min_y, box_min_z;
  logic signed [31:0] box_max_x, box_max_y, box_max_z;
  logic signed [31:0] seg_origin_x, seg_origin_y, seg_origin_z;
  logic signed [31:0] seg_dir_x, seg_dir_y, seg_dir_z;
  logic out_valid;
  logic out_ready;
  logic hit;

  bit hit_queue [$];  // expected hit flags, oldest first
  int n_fail;
  bit stim_done;

  segment_aabb_slab_test_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
    .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
    .seg_origin_x(seg_origin_x), .seg_origin_y(seg_origin_y),
    .seg_origin_z(seg_origin_z),
    .seg_dir_x(seg_dir_x), .seg_dir_y(seg_dir_y), .seg_dir_z(seg_dir_z),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Slab parameter: ((bound - origin) << FRAC) / dir, truncating toward zero,
  // then clamped to the signed 32-bit range.
  function automatic longint slab_t(longint num, longint den);
    longint q;
    q = (num * ONE) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit predict_hit(seg_req_t r);
    longint lo, hi, o, d, t1, t2, near_t, far_t;
    bit ok;
    near_t = T_NONE_LO;
    far_t = T_NONE_HI;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo = r.bmin[a];
      hi = r.bmax[a];
      o = r.org[a];
      d = r.dir[a];
      if (d == 0) begin
        // Parallel axis: inside the slab sets no limit, outside is a miss.
        if (lo > hi) begin
          t1 = lo; lo = hi; hi = t1;
        end
        if (o < lo || o > hi) ok = 1'b0;
      end else begin
        t1 = slab_t(lo - o, d);
        t2 = slab_t(hi - o, d);
        if (t1 > t2) begin
          lo = t1; t1 = t2; t2 = lo;
        end
        if (t1 > near_t) near_t = t1;
        if (t2 < far_t) far_t = t2;
      end
    end
    if (ok) begin
      if ((near_t < 0 && far_t < 0) || (near_t > ONE && far_t > ONE)) ok = 1'b0;
      else if (!(near_t < far_t)) ok = 1'b0;  // touching counts as a miss
    end
    return ok;
  endfunction

  function automatic seg_req_t mk(logic signed [31:0] mn0, mn1, mn2, mx0, mx1, mx2,
                                  o0, o1, o2, d0, d1, d2);
    seg_req_t r;
    r.bmin = '{mn0, mn1, mn2};
    r.bmax = '{mx0, mx1, mx2};
    r.org  = '{o0, o1, o2};
    r.dir  = '{d0, d1, d2};
    return r;
  endfunction

  // Mostly small Q16.16 values near the box, sometimes any 32-bit pattern.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2: return 32'sd0;
      default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic seg_req_t rand_req();
    seg_req_t r;
    logic signed [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = rand_coord();
      b = rand_coord();
      // keep most boxes well ordered, a few swapped
      if ($urandom_range(0, 7) != 0 && a > b) begin
        r.bmin[i] = b; r.bmax[i] = a;
      end else begin
        r.bmin[i] = a; r.bmax[i] = b;
      end
      r.org[i] = rand_coord();
      r.dir[i] = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_coord();
    end
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Present one request and hold it until in_ready takes it.
  task automatic send_req(seg_req_t r, bit exp_hit);
    in_valid <= 1'b1;
    box_min_x <= r.bmin[0]; box_min_y <= r.bmin[1]; box_min_z <= r.bmin[2];
    box_max_x <= r.bmax[0]; box_max_y <= r.bmax[1]; box_max_z <= r.bmax[2];
    seg_origin_x <= r.org[0]; seg_origin_y <= r.org[1]; seg_origin_z <= r.org[2];
    seg_dir_x <= r.dir[0]; seg_dir_y <= r.dir[1]; seg_dir_z <= r.dir[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit_queue.push_back(exp_hit);
  endtask

  task automatic drop_valid_maybe();
    // One time in three, valid drops low before the next request, so it never toggles within a step.
    if ($urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
  endtask

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    seg_req_t r;
    bit e;

    rst = 1'b1;
    in_valid = 1'b0;
    {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} = '0;
    {seg_origin_x, seg_origin_y, seg_origin_z, seg_dir_x, seg_dir_y, seg_dir_z} = '0;
    n_fail = 0;
    stim_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Unit box [0,1]^3 unless noted.
    // straight through along x
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, -Q1,Q1/2,Q1/2, 3*Q1,0,0), EXP_HIT});
    // all directions zero, start inside / outside
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, Q1/2,Q1/2,Q1/2, 0,0,0), EXP_HIT});
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, 2*Q1,Q1/2,Q1/2, 0,0,0), EXP_MISS});
    // parallel axis outside the slab forces a miss
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, -Q1,2*Q1,Q1/2, 3*Q1,0,0), EXP_MISS});
    // segment ends before the box / starts after it
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, -3*Q1,Q1/2,Q1/2, Q1,0,0), EXP_MISS});
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, 2*Q1,Q1/2,Q1/2, Q1,0,0), EXP_MISS});
    // swapped corners
    rows.push_back('{mk(Q1,Q1,Q1,0,0,0, -Q1,Q1/2,Q1/2, 3*Q1,0,0), EXP_HIT});
    // grazing an edge: entry equals exit
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, -Q1,0,Q1/2, 2*Q1,2*Q1,0), EXP_PREDICT});
    // parallel exactly on the boundary (bounds included)
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, -Q1,Q1,Q1/2, 3*Q1,0,0), EXP_HIT});
    // reverse direction, diagonal
    rows.push_back('{mk(0,0,0,Q1,Q1,Q1, 2*Q1,2*Q1,2*Q1, -3*Q1,-3*Q1,-3*Q1), EXP_HIT});
    // extremes: saturating quotients
    rows.push_back('{mk(32'sh8000_0000,32'sh8000_0000,32'sh8000_0000,
                        32'sh7fff_ffff,32'sh7fff_ffff,32'sh7fff_ffff,
                        0,0,0, 1,1,1), EXP_PREDICT});
    rows.push_back('{mk(32'sh7fff_ffff,32'sh7fff_ffff,32'sh7fff_ffff,
                        32'sh8000_0000,32'sh8000_0000,32'sh8000_0000,
                        32'sh8000_0000,32'sh7fff_ffff,0,
                        32'sh7fff_ffff,32'sh8000_0000,-1), EXP_PREDICT});
    rows.push_back('{mk(-1,-1,-1,-1,-1,-1, -1,-1,-1,
                        32'sh8000_0000,32'sh8000_0000,32'sh8000_0000), EXP_PREDICT});
    rows.push_back('{mk(0,0,0,0,0,0, 0,0,0, 0,0,0), EXP_HIT});
    rows.push_back('{mk(32'sh5555_5555,32'shaaaa_aaaa,32'sh5555_5555,
                        32'shaaaa_aaaa,32'sh5555_5555,32'shaaaa_aaaa,
                        32'sh5555_5555,32'shaaaa_aaaa,32'sh0,
                        32'shaaaa_aaaa,32'sh5555_5555,32'sh7fff_ffff), EXP_PREDICT});

    foreach (rows[i]) begin
      row = rows[i];
      e = (row.exp == EXP_PREDICT) ? predict_hit(row.req) : (row.exp == EXP_HIT);
      if (row.exp != EXP_PREDICT && e != predict_hit(row.req)) begin
        $error("table row %0d disagrees with predictor", i);
        n_fail++;
      end
      send_req(row.req, e);
      drop_valid_maybe();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      r = rand_req();
      send_req(r, predict_hit(r));
      drop_valid_maybe();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random back-pressure, with no-stall stretches.
  initial begin
    int calm;
    out_ready = 1'b0;
    calm = 0;
    forever begin
      @(posedge clk);
      if (calm > 0) begin
        calm--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 30) == 0) begin
        calm = $urandom_range(20, 100);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 40) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hit_queue.size() == 0) begin
        $error("unexpected result: hit=%0b", hit);
        n_fail++;
      end else begin
        bit exp_hit;
        exp_hit = hit_queue.pop_front();
        if (hit !== exp_hit) begin
          $error("hit mismatch: expected %0b actual %0b", exp_hit, hit);
          n_fail++;
        end
      end
    end
  end

  // End of run: drain, then idle so stray results are caught before the report.
  initial begin
    wait (stim_done);
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (n_fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sast_pkg.sv
hw/rtl/sast_div_cell.sv
hw/rtl/sast_resolve.sv
hw/rtl/segment_aabb_slab_test_core.sv
tb/sv/tb_segment_aabb_slab_test_core.sv
